// ----- src/gld_pkg.sv -----
// shared constants, types and helpers for the gif lzw decoder
package gld_pkg;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned SIZE_W    = 4;
    localparam int unsigned OUT_W     = 16;
    localparam logic [3:0]  SIZE_RST  = 4'd8;
    localparam logic [3:0]  SIZE_LO   = 4'd2;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_PULL = 1'b1
    } t_op;

    // clamp the minimum code size into the legal range
    function automatic logic [3:0] clamp_size(input logic [3:0] v, input logic [3:0] hi);
        logic [3:0] s;
        s = v;
        if (s < SIZE_LO) s = SIZE_LO;
        if (s > hi) s = hi;
        return s;
    endfunction

endpackage

// ----- src/gld_dict.sv -----
// lzw dictionary: prefix and suffix memories, one write and one registered read port
module gld_dict #(
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned ADDR_W = 12,
    parameter int unsigned CODE_W = 12
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [ADDR_W-1:0]              i_waddr,
    input  logic [CODE_W-1:0]              i_wprefix,
    input  logic [gld_pkg::PIX_W-1:0]      i_wsuffix,
    input  logic [ADDR_W-1:0]              i_raddr,
    output logic [CODE_W-1:0]              o_rprefix,
    output logic [gld_pkg::PIX_W-1:0]      o_rsuffix
);
    import gld_pkg::*;

    logic [CODE_W-1:0] r_prefix_mem [DEPTH];
    logic [PIX_W-1:0]  r_suffix_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_prefix_mem[i_waddr] <= i_wprefix;
            r_suffix_mem[i_waddr] <= i_wsuffix;
        end
        o_rprefix <= r_prefix_mem[i_raddr];
        o_rsuffix <= r_suffix_mem[i_raddr];
    end

endmodule

// ----- src/gif_lzw_decoder_core.sv -----
// gif lzw decoder top level: byte unpacking, code sequencer, pixel stack
//
// channel  | dir | fields (low bit first)
// s_axis   | in  | tuser: op; tdata: data_byte
// m_axis   | out | tdata: pixel, pixel_valid, need_byte, finished, protocol_error
// cfg      | in  | i_cfg_wdata: min_code_size
//
// a pull goes through S_POP and then S_CODE, which decodes the next code when the stack empties;
// a data byte goes to S_CODE, where each code is taken, then walks the dictionary chain through
// S_WALK and S_READ (one registered dictionary read per step), ends the walk in S_WALK and adds
// the new entry in S_ADD; a clear, an end code or the first code after a clear takes only S_CODE.
// one word is in flight at a time; s_axis_tready stays low until the result is taken.
// reset is synchronous; the memories are not cleared.
module gif_lzw_decoder_core #(
    parameter int unsigned TABLE_ENTRIES = 4096,
    parameter int unsigned MAX_CODE_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // data_byte
    input  logic                           s_axis_tuser,  // op
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [gld_pkg::OUT_W-1:0]      m_axis_tdata,  // pixel, pixel_valid,
                                                          // need_byte, finished,
                                                          // protocol_error
    input  logic                           i_cfg_we,
    input  logic [gld_pkg::SIZE_W-1:0]     i_cfg_wdata    // min_code_size
);
    import gld_pkg::*;

    localparam int unsigned AW    = $clog2(TABLE_ENTRIES);
    localparam int unsigned SW    = AW + 1;
    localparam int unsigned CW    = MAX_CODE_BITS;
    localparam int unsigned NW    = MAX_CODE_BITS + 1;
    localparam int unsigned BW    = MAX_CODE_BITS + 8;
    localparam int unsigned CNTW  = $clog2(BW + 1);
    localparam logic [3:0] SIZE_HI = (MAX_CODE_BITS - 1 < 9) ?
                                     4'(MAX_CODE_BITS - 1) : 4'd9;
    localparam logic [3:0] WIDTH_MAX = 4'(MAX_CODE_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_CODE,
        S_WALK,
        S_READ,
        S_ADD
    } t_state;

    t_state            r_state;
    logic [3:0]        r_min_size;
    logic [SW-1:0]     r_depth;
    logic [NW-1:0]     r_next;
    logic [NW-1:0]     r_limit;
    logic [3:0]        r_width;
    logic [CW-1:0]     r_old;
    logic [PIX_W-1:0]  r_first;
    logic [BW-1:0]     r_buf;
    logic [CNTW-1:0]   r_cnt;
    logic [7:0]        r_left;
    logic              r_after;
    logic              r_done;
    logic [CW-1:0]     r_code;
    logic [CW-1:0]     r_c;
    logic [SW-1:0]     r_steps;
    logic [PIX_W-1:0]  r_pix;
    logic              r_valid;
    logic              r_err;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic [PIX_W-1:0]  r_stack_mem [TABLE_ENTRIES];
    logic [PIX_W-1:0]  r_stack_rd;

    logic [3:0]        w_size;
    logic [NW-1:0]     w_clr, w_endc, w_newc;
    logic [3:0]        w_ini_size;
    logic [CW-1:0]     w_code;
    logic [NW-1:0]     w_cx;
    logic              w_have_code;
    logic              w_push;
    logic [PIX_W-1:0]  w_push_val;
    logic              w_dict_we;
    logic [CW-1:0]     w_rprefix;
    logic [PIX_W-1:0]  w_rsuffix;
    logic              w_accept;
    logic              w_need;
    logic [NW-1:0]     w_next_inc;
    logic              w_grow;
    logic              w_walk_go;
    logic              w_code_in_table;

    assign w_size      = clamp_size(r_min_size, SIZE_HI);
    assign w_clr       = NW'(1) << w_size;
    assign w_endc      = w_clr + NW'(1);
    assign w_newc      = w_clr + NW'(2);
    assign w_ini_size  = !i_rst_n ? clamp_size(SIZE_RST, SIZE_HI)
                                  : clamp_size(i_cfg_wdata, SIZE_HI);

    assign w_code      = CW'(r_buf & ~({BW{1'b1}} << r_width));
    assign w_cx        = NW'(w_code);
    assign w_have_code = !r_done && (r_depth == '0) && (r_cnt >= CNTW'(r_width));
    assign w_need      = (r_depth == '0) && (r_cnt < CNTW'(r_width)) && !r_done;

    assign w_grow      = r_next < r_limit;
    assign w_next_inc  = w_grow ? r_next + NW'(1) : r_next;
    assign w_walk_go   = (NW'(r_code) >= w_newc) && (32'(r_steps) < TABLE_ENTRIES);
    assign w_code_in_table = 32'(r_code) < TABLE_ENTRIES;

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // which cycles write a pixel onto the stack and a new entry into the dictionary
    always_comb begin
        w_push     = 1'b0;
        w_push_val = '0;
        w_dict_we  = 1'b0;
        unique case (r_state)
            S_CODE: begin
                if (w_have_code) begin
                    if (r_after) begin
                        if (w_cx != w_clr && w_cx != w_endc) begin
                            w_push     = 1'b1;
                            w_push_val = (w_cx >= r_next) ? '0 : w_code[PIX_W-1:0];
                        end
                    end else if (w_cx != w_endc && w_cx != w_clr && w_cx >= r_next) begin
                        w_push     = 1'b1;
                        w_push_val = r_first;
                    end
                end
            end
            S_WALK: begin
                if (w_walk_go && !w_code_in_table) begin
                    w_push     = 1'b1;
                    w_push_val = '0;
                end
            end
            S_READ: begin
                w_push     = 1'b1;
                w_push_val = w_rsuffix;
            end
            S_ADD: begin
                w_push     = 1'b1;
                w_push_val = r_code[PIX_W-1:0];
                w_dict_we  = w_grow && (32'(r_next) < TABLE_ENTRIES);
            end
            default: ;
        endcase
    end

    gld_dict #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (AW),
        .CODE_W (CW)
    ) u_dict (
        .i_clk     (i_clk),
        .i_we      (w_dict_we),
        .i_waddr   (AW'(r_next)),
        .i_wprefix (r_old),
        .i_wsuffix (r_code[PIX_W-1:0]),
        .i_raddr   (AW'(r_code)),
        .o_rprefix (w_rprefix),
        .o_rsuffix (w_rsuffix)
    );

    // pixel stack, read address is the top entry
    always_ff @(posedge i_clk) begin
        if (w_push && (32'(r_depth) < TABLE_ENTRIES)) begin
            r_stack_mem[r_depth[AW-1:0]] <= w_push_val;
        end
        r_stack_rd <= r_stack_mem[r_depth[AW-1:0] - AW'(1)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            if (!i_rst_n) begin
                r_min_size  <= SIZE_RST;
                r_state     <= S_IDLE;
                r_out_valid <= 1'b0;
            end else begin
                r_min_size  <= i_cfg_wdata;
            end
            r_depth <= '0;
            r_width <= w_ini_size + 4'd1;
            r_limit <= NW'(1) << (w_ini_size + 4'd1);
            r_next  <= (NW'(1) << w_ini_size) + NW'(2);
            r_old   <= '0;
            r_first <= '0;
            r_buf   <= '0;
            r_cnt   <= '0;
            r_left  <= '0;
            r_after <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) r_out_valid <= 1'b0;
            if (w_push && (32'(r_depth) < TABLE_ENTRIES)) r_depth <= r_depth + SW'(1);

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pix   <= '0;
                        r_valid <= 1'b0;
                        r_err   <= 1'b0;
                        r_state <= S_CODE;
                        if (t_op'(s_axis_tuser) == OP_PULL) begin
                            if (r_depth == '0) begin
                                r_err <= 1'b1;
                            end else begin
                                r_depth <= r_depth - SW'(1);
                                r_valid <= 1'b1;
                                r_state <= S_POP;
                            end
                        end else if (!r_done) begin
                            if (r_depth != '0 || r_cnt >= CNTW'(r_width)) begin
                                r_err <= 1'b1;
                            end else if (r_left == '0) begin
                                if (s_axis_tdata == '0) begin
                                    r_done <= 1'b1;
                                    r_buf  <= '0;
                                    r_cnt  <= '0;
                                end else begin
                                    r_left <= s_axis_tdata;
                                end
                            end else begin
                                r_buf  <= r_buf | (BW'(s_axis_tdata) << r_cnt);
                                r_cnt  <= r_cnt + CNTW'(8);
                                r_left <= r_left - 8'd1;
                            end
                        end
                    end
                end
                S_POP: begin
                    r_pix   <= r_stack_rd;
                    r_state <= S_CODE;
                end
                S_CODE: begin
                    if (w_have_code) begin
                        if (w_cx == w_endc) begin
                            r_done <= 1'b1;
                            r_buf  <= '0;
                            r_cnt  <= '0;
                        end else begin
                            r_buf <= r_buf >> r_width;
                            r_cnt <= r_cnt - CNTW'(r_width);
                            if (r_after) begin
                                if (w_cx != w_clr) begin
                                    r_old   <= (w_cx >= r_next) ? '0 : w_code;
                                    r_first <= (w_cx >= r_next) ? '0 : w_code[PIX_W-1:0];
                                    r_after <= 1'b0;
                                end
                            end else if (w_cx == w_clr) begin
                                r_width <= w_size + 4'd1;
                                r_next  <= w_newc;
                                r_limit <= NW'(1) << (w_size + 4'd1);
                                r_after <= 1'b1;
                            end else begin
                                r_c     <= w_code;
                                r_code  <= (w_cx >= r_next) ? r_old : w_code;
                                r_steps <= '0;
                                r_state <= S_WALK;
                            end
                        end
                    end else begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {{(OUT_W - PIX_W - 4){1'b0}}, r_err, r_done,
                                        w_need, r_valid, r_pix};
                        r_state     <= S_IDLE;
                    end
                end
                S_WALK: begin
                    if (w_walk_go) begin
                        if (w_code_in_table) begin
                            r_state <= S_READ;
                        end else begin
                            r_code  <= '0;
                            r_steps <= r_steps + SW'(1);
                        end
                    end else begin
                        r_state <= S_ADD;
                    end
                end
                S_READ: begin
                    r_code  <= w_rprefix;
                    r_steps <= r_steps + SW'(1);
                    r_state <= S_WALK;
                end
                S_ADD: begin
                    if (w_grow) begin
                        r_first <= r_code[PIX_W-1:0];
                        r_next  <= w_next_inc;
                        r_old   <= r_c;
                    end
                    // widen the code once the current range is used up
                    if (w_next_inc >= r_limit && r_width < WIDTH_MAX) begin
                        r_limit <= r_limit << 1;
                        r_width <= r_width + 4'd1;
                    end
                    r_state <= S_CODE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- tb/sv/gif_lzw_decoder_core_test.sv -----
// self-checking testbench for the gif lzw decoder core
module gif_lzw_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gld_pkg::*;

    localparam int unsigned DICT_SIZE  = 4096;
    localparam int unsigned WIDEST     = 12;
    localparam int unsigned STALL_MAX  = 40000;
    localparam int unsigned HOLD_LEN   = 400;

    // packed from the top bit down, so pixel lands in the low byte
    typedef struct packed {
        logic       err;
        logic       fin;
        logic       need;
        logic       valid;
        logic [7:0] pixel;
    } t_pix_word;

    // how the stream builder picks the next code
    typedef enum int {
        K_RAND,
        K_LIT_MIN,
        K_LIT_MAX,
        K_NEXT,
        K_DEF,
        K_WILD,
        K_CLEAR
    } t_pick;

    // shadow lzw decoder plus the queue of expected result words
    class pixel_scoreboard;
        bit [11:0]   prefix_mem [DICT_SIZE];
        bit [7:0]    suffix_mem [DICT_SIZE];
        bit [7:0]    stack_mem  [DICT_SIZE];
        int unsigned size_reg;
        int unsigned depth, nslot, slimit, cwidth, oldc, firstc;
        int unsigned bitbuf, bitcnt, blk_left;
        bit          after_clr, done;
        t_pix_word   expq[$];
        int unsigned errors, checked, pixels;

        function new();
            size_reg = SIZE_RST;
            restart();
        endfunction

        function int unsigned eff_size();
            int unsigned s;
            s = size_reg & 15;
            if (s < 2) s = 2;
            if (s > 9) s = 9;
            return s;
        endfunction

        function void restart();
            int unsigned s;
            s = eff_size();
            depth = 0;
            cwidth = s + 1;
            slimit = 1 << cwidth;
            nslot = (1 << s) + 2;
            oldc = 0;
            firstc = 0;
            bitbuf = 0;
            bitcnt = 0;
            blk_left = 0;
            after_clr = 0;
            done = 0;
        endfunction

        function void set_size(int unsigned v);
            size_reg = v & 15;
            restart();
        endfunction

        function void put_px(int unsigned v);
            if (depth < DICT_SIZE) begin
                stack_mem[depth] = 8'(v);
                depth++;
            end
        endfunction

        function void stop();
            done = 1;
            bitbuf = 0;
            bitcnt = 0;
        endfunction

        function void take_code(int unsigned c);
            int unsigned s, clr, endc, newc, code, steps;
            s = eff_size();
            clr = 1 << s;
            endc = clr + 1;
            newc = clr + 2;
            if (after_clr) begin
                if (c == clr) return;
                if (c == endc) begin
                    stop();
                    return;
                end
                if (c >= nslot) c = 0;
                oldc = c;
                firstc = c & 255;
                put_px(c);
                after_clr = 0;
                return;
            end
            if (c == endc) begin
                stop();
                return;
            end
            if (c == clr) begin
                cwidth = s + 1;
                nslot = newc;
                slimit = 1 << cwidth;
                after_clr = 1;
                return;
            end
            code = c;
            // kwkwk: code not in the table yet
            if (code >= nslot) begin
                code = oldc;
                put_px(firstc);
            end
            steps = 0;
            while (code >= newc && steps < DICT_SIZE) begin
                if (code < DICT_SIZE) begin
                    put_px(suffix_mem[code]);
                    code = prefix_mem[code];
                end else begin
                    put_px(0);
                    code = 0;
                end
                steps++;
            end
            put_px(code);
            if (nslot < slimit) begin
                firstc = code & 255;
                if (nslot < DICT_SIZE) begin
                    suffix_mem[nslot] = 8'(code);
                    prefix_mem[nslot] = 12'(oldc);
                end
                nslot++;
                oldc = c;
            end
            if (nslot >= slimit && cwidth < WIDEST) begin
                slimit <<= 1;
                cwidth++;
            end
        endfunction

        function void run_codes();
            int unsigned c;
            while (!done && depth == 0 && bitcnt >= cwidth) begin
                c = bitbuf & ((1 << cwidth) - 1);
                bitbuf >>= cwidth;
                bitcnt -= cwidth;
                take_code(c);
            end
        endfunction

        function void note_item(t_op op, logic [7:0] b);
            t_pix_word w;
            w = '0;
            if (op == OP_PULL) begin
                if (depth == 0) begin
                    w.err = 1;
                end else begin
                    depth--;
                    w.pixel = stack_mem[depth];
                    w.valid = 1;
                    run_codes();
                end
            end else if (!done) begin
                if (depth != 0 || bitcnt >= cwidth) begin
                    w.err = 1;
                end else if (blk_left == 0) begin
                    if (b == 0) stop();
                    else blk_left = b;
                end else begin
                    bitbuf = (bitbuf | (int'(b) << bitcnt)) & 20'hFFFFF;
                    bitcnt += 8;
                    blk_left--;
                    run_codes();
                end
            end
            w.need = (depth == 0 && bitcnt < cwidth && !done);
            w.fin = done;
            expq.push_back(w);
        endfunction

        function void check_word(logic [OUT_W-1:0] data);
            t_pix_word got, want;
            got = data[11:0];
            if (expq.size() == 0) begin
                $error("result word with nothing expected: %h", data);
                errors++;
                return;
            end
            want = expq.pop_front();
            checked++;
            if (got.valid) pixels++;
            if (got.pixel !== want.pixel) begin
                $error("pixel expected %0d got %0d", want.pixel, got.pixel);
                errors++;
            end
            if (got.valid !== want.valid) begin
                $error("pixel_valid expected %0d got %0d", want.valid, got.valid);
                errors++;
            end
            if (got.need !== want.need) begin
                $error("need_byte expected %0d got %0d", want.need, got.need);
                errors++;
            end
            if (got.fin !== want.fin) begin
                $error("finished expected %0d got %0d", want.fin, got.fin);
                errors++;
            end
            if (got.err !== want.err) begin
                $error("protocol_error expected %0d got %0d", want.err, got.err);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;   // data_byte
    logic               s_axis_tuser = 1'b0; // op
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;        // pixel, pixel_valid, need_byte,
                                             // finished, protocol_error
    logic               i_cfg_we = 1'b0;
    logic [SIZE_W-1:0]  i_cfg_wdata = '0;    // min_code_size

    pixel_scoreboard    sb = new();
    bit                 quiet = 0;
    bit                 hold_req = 0;
    int unsigned        n_items = 0;
    int unsigned        n_phases = 0;
    int unsigned        stall_cnt = 0;
    logic [7:0]         stream_q[$];

    // stream builder's view of the code width progression
    int unsigned        g_width, g_next, g_limit;
    bit                 g_after;
    longint unsigned    g_acc;
    int unsigned        g_nbits;
    logic [7:0]         g_bytes[$];

    gif_lzw_decoder_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // result checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_MAX) begin
                $display("watchdog: no word moved for %0d cycles", STALL_MAX);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // receiver: random back-pressure and one long hold-off
    initial begin
        @(posedge i_clk iff i_rst_n);
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                m_axis_tready <= 1'b1;
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(t_op op, logic [7:0] b);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(op, b);
        n_items++;
    endtask

    task automatic emit_code(int unsigned c);
        int unsigned s;
        s = sb.eff_size();
        g_acc |= longint'(c) << g_nbits;
        g_nbits += g_width;
        while (g_nbits >= 8) begin
            g_bytes.push_back(8'(g_acc));
            g_acc >>= 8;
            g_nbits -= 8;
        end
        if (g_after) begin
            if (c != (1 << s)) g_after = 0;
        end else if (c == (1 << s)) begin
            g_width = s + 1;
            g_next = (1 << s) + 2;
            g_limit = 1 << g_width;
            g_after = 1;
        end else begin
            if (g_next < g_limit) g_next++;
            if (g_next >= g_limit && g_width < WIDEST) begin
                g_limit <<= 1;
                g_width++;
            end
        end
    endtask

    // codes with random content, then end code or zero-length block, then junk
    task automatic build_stream(int unsigned ncodes, bit lit_heavy, t_pick forced[$]);
        int unsigned s, clr, c, r, len, left;
        t_pick pick;
        bit end_by_code;
        s = sb.eff_size();
        clr = 1 << s;
        g_width = s + 1;
        g_next = clr + 2;
        g_limit = 1 << g_width;
        g_after = 0;
        g_acc = 0;
        g_nbits = 0;
        g_bytes = {};
        for (int i = 0; i < ncodes; i++) begin
            if (forced.size() != 0) begin
                pick = forced.pop_front();
            end else begin
                r = $urandom_range(0, 99);
                if (lit_heavy) pick = (r < 96) ? K_RAND : K_NEXT;
                else if (r < 4) pick = K_CLEAR;
                else if (r < 9) pick = K_NEXT;
                else if (r < 12) pick = K_WILD;
                else if (r < 50) pick = K_RAND;
                else pick = K_DEF;
            end
            case (pick)
                K_LIT_MIN: c = 0;
                K_LIT_MAX: c = clr - 1;
                K_NEXT:    c = g_next;
                K_CLEAR:   c = clr;
                K_WILD: begin
                    do c = $urandom_range(0, (1 << g_width) - 1);
                    while (c == clr || c == clr + 1);
                end
                K_DEF: begin
                    do c = $urandom_range(0, g_next - 1);
                    while (c == clr || c == clr + 1);
                end
                default:   c = $urandom_range(0, clr - 1);
            endcase
            emit_code(c);
        end
        end_by_code = $urandom_range(0, 2) != 0;
        if (end_by_code) emit_code(clr + 1);
        if (g_nbits != 0) g_bytes.push_back(8'(g_acc));
        stream_q = {};
        while (g_bytes.size() != 0) begin
            left = g_bytes.size();
            if (lit_heavy) len = 255;
            else if ($urandom_range(0, 3) == 0) len = $urandom_range(1, 255);
            else len = $urandom_range(1, 16);
            if (len > left) len = left;
            stream_q.push_back(8'(len));
            repeat (len) stream_q.push_back(g_bytes.pop_front());
        end
        if (!end_by_code || $urandom_range(0, 1)) stream_q.push_back(8'd0);
        repeat ($urandom_range(0, 3)) stream_q.push_back(8'($urandom));
    endtask

    // pulls while pixels wait, pushes otherwise, with some misplaced words
    task automatic run_stream();
        forever begin
            if (sb.depth != 0) begin
                if ($urandom_range(0, 19) == 0) send_item(OP_PUSH, 8'($urandom));
                else send_item(OP_PULL, 8'($urandom));
            end else if (stream_q.size() == 0) begin
                break;
            end else if ($urandom_range(0, 19) == 0) begin
                send_item(OP_PULL, 8'($urandom));
            end else begin
                send_item(OP_PUSH, stream_q.pop_front());
            end
        end
        s_axis_tvalid <= 1'b0;
        n_phases++;
    endtask

    task automatic new_image(int unsigned size);
        while (sb.expq.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= SIZE_W'(size);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_size(size);
    endtask

    initial begin
        t_pick none[$];
        int unsigned sizes[$];
        none = {};
        sizes = '{2, 9, 0, 15, 3, 1};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty pull, literal extremes, kwkwk, repeated clear,
        // out-of-range first code after a clear
        send_item(OP_PULL, 8'hFF);
        build_stream(10, 0, '{K_LIT_MIN, K_LIT_MAX, K_NEXT, K_DEF, K_CLEAR,
                              K_CLEAR, K_NEXT, K_WILD, K_DEF, K_NEXT});
        run_stream();

        while (n_items < 900 || sizes.size() != 0) begin
            new_image(sizes.size() != 0 ? sizes.pop_front() : $urandom_range(0, 15));
            if (n_phases == 3) hold_req = 1;
            build_stream($urandom_range(10, 40), 0, none);
            run_stream();
        end

        quiet = 1;
        new_image(SIZE_RST);
        build_stream(30, 0, none);
        run_stream();

        while (sb.expq.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("%0d words sent over %0d images, %0d results checked, %0d pixels",
                 n_items, n_phases, sb.checked, sb.pixels);
        $display("code sizes 0..15 with clamping, clears, kwkwk codes and misplaced words");
        if (sb.errors == 0 && sb.expq.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/gld_pkg.sv
src/gld_dict.sv
src/gif_lzw_decoder_core.sv
tb/sv/gif_lzw_decoder_core_test.sv
